[sv/ssb_pkg.sv]
// Package for the scaled sprite blitter: item types, kind codes, FSM states
// and sizing constants. No dependencies.
package ssb_pkg;

    localparam int SCREEN_W_DEF    = 128;
    localparam int SCREEN_H_DEF    = 128;
    localparam int BG_RES_DEF      = 128;
    localparam int SPRITE_RES_DEF  = 32;
    localparam int IMAGE_WORDS_DEF = 65536;

    localparam logic [15:0] OPAQUE_WHITE = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_DRAW = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        address;
        logic [15:0]        pixel_value;
        logic [15:0]        image_base;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic [7:0]         width_ratio;
        logic [7:0]         height_ratio;
        logic               is_background;
    } item_t;

    typedef struct packed {
        logic [15:0] read_color;
        logic [1:0]  done_kind;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_DIV,
        ST_PIX,
        ST_READ,
        ST_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;     // latch the item
        logic size_start;  // compute drawn size from ratios
        logic div_start;   // start row/column source index divides
        logic pix_issue;   // issue the current pixel's image read
        logic read_issue;  // issue frame read
        logic finish;      // drive the result strobe
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;       // drawn size is zero
        logic div_done;    // source indices ready
        logic pix_last;    // current pixel is the last one of the blit
        logic row_end;     // current pixel ends its row
        logic drain;       // write pipeline empty
    } ctrl_stat_t;

endpackage

[sv/scaled_sprite_blitter_unit.sv]
// Top level of the scaled sprite blitter: controller plus datapath.
// Depends on ssb_pkg, ssb_ctrl, ssb_datapath.
//
//  channel   signals                       direction
//  command   start, item; busy             in; out
//  result    done, result                  out
//
// After the accepting edge, a load or an unused kind goes straight to the
// done state and a read passes through the read state first. Draw: a size
// step, then per pixel a setup step, a restoring divide over the NW-bit
// dividend (NW = 16 at the defaults) and an issue step, then a wait for
// the write pipeline to drain before done; a zero size skips the pixels.
// Reset clears control only; both stores are undefined until written.
// done is a one-cycle strobe; the receiver cannot stall it.
module scaled_sprite_blitter_unit
    import ssb_pkg::*;
#(
    parameter int SCREEN_W    = SCREEN_W_DEF,
    parameter int SCREEN_H    = SCREEN_H_DEF,
    parameter int BG_RES      = BG_RES_DEF,
    parameter int SPRITE_RES  = SPRITE_RES_DEF,
    parameter int IMAGE_WORDS = IMAGE_WORDS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    ssb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ssb_datapath #(
        .SCREEN_W    (SCREEN_W),
        .SCREEN_H    (SCREEN_H),
        .BG_RES      (BG_RES),
        .SPRITE_RES  (SPRITE_RES),
        .IMAGE_WORDS (IMAGE_WORDS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    assign done = cmd.finish;

endmodule

[sv/ssb_ctrl.sv]
// Controller state machine of the scaled sprite blitter.
// Depends on ssb_pkg.
module ssb_ctrl
    import ssb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] kind,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    priority if (kind == KIND_DRAW)
                        state_next = ST_SIZE;
                    else if (kind == KIND_READ)
                        state_next = ST_READ;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SIZE:
            begin
                cmd.size_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                priority if (stat.empty)
                    state_next = ST_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_PIX;
                end
            end
            ST_PIX:
            begin
                // every pixel needs its own column divide
                if (stat.div_done)
                begin
                    cmd.pix_issue = 1'b1;
                    priority if (stat.pix_last)
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the last pixel write to land
                if (stat.drain)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

[sv/ssb_datapath.sv]
// Datapath of the scaled sprite blitter: stores, size and index arithmetic,
// pixel write pipeline. Depends on ssb_pkg.
module ssb_datapath
    import ssb_pkg::*;
#(
    parameter int SCREEN_W    = SCREEN_W_DEF,
    parameter int SCREEN_H    = SCREEN_H_DEF,
    parameter int BG_RES      = BG_RES_DEF,
    parameter int SPRITE_RES  = SPRITE_RES_DEF,
    parameter int IMAGE_WORDS = IMAGE_WORDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  ctrl_cmd_t  cmd,
    output ctrl_stat_t stat,
    output result_t    result
);

    localparam int FRAME_WORDS = SCREEN_W * SCREEN_H;
    localparam int IW = $clog2(IMAGE_WORDS);
    localparam int FW = $clog2(FRAME_WORDS);
    localparam int XW = $clog2(SCREEN_W + 1);
    localparam int YW = $clog2(SCREEN_H + 1);
    localparam int SW = (XW > YW) ? XW : YW;        // size width
    localparam int MAXRES = (BG_RES > SPRITE_RES) ? BG_RES : SPRITE_RES;
    localparam int RW = $clog2(MAXRES + 1);
    localparam int NW = SW + RW;                     // dividend width
    localparam int QW = $clog2(MAXRES);              // index width
    localparam int DCW = $clog2(NW + 1);

    // floor(n/255) as (n*K) >> 26, exact for every n below 2^18
    localparam longint DIV255_K = 263173;
    localparam longint W_MUL    = SCREEN_W * DIV255_K;
    localparam longint H_MUL    = SCREEN_H * DIV255_K;

    logic [15:0] frame_mem [FRAME_WORDS];
    logic [15:0] image_mem [IMAGE_WORDS];

    item_t        item_reg;
    logic [SW-1:0] w_reg, h_reg, x_reg, y_reg;
    logic [RW-1:0] res;

    // shared restoring divider, runs column and row divides in parallel lanes
    logic [NW-1:0]  cn_reg, rn_reg;
    logic [SW:0]    cr_reg, rr_reg;
    logic [QW-1:0]  cq_reg, rq_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           dbusy_reg;
    logic           rowdiv_reg;

    // pixel pipeline: image read then frame write
    logic           p_valid_reg;
    logic           p_on_reg;
    logic [FW-1:0]  p_faddr_reg;
    logic [15:0]    img_q_reg;
    logic [15:0]    frd_q_reg;
    logic           rd_ok_reg;

    logic signed [17:0] px, py;
    logic on_scr;
    logic [IW-1:0] iaddr;
    logic [SW:0] c_try, r_try;
    logic [FW:0] faddr_wide;

    assign res = item_reg.is_background ? RW'(BG_RES) : RW'(SPRITE_RES);

    assign px = 18'(item_reg.screen_x) + 18'(x_reg);
    assign py = 18'(item_reg.screen_y) + 18'(y_reg);
    assign on_scr = (px >= 0) && (px < 18'(SCREEN_W)) && (py >= 0) && (py < 18'(SCREEN_H));
    assign iaddr = IW'(32'(item_reg.image_base) + 32'(rq_reg) * 32'(res) + 32'(cq_reg));
    assign faddr_wide = (FW+1)'(py) * (FW+1)'(SCREEN_W) + (FW+1)'(px);

    assign c_try = {cr_reg[SW-1:0], cn_reg[NW-1]} - {1'b0, w_reg};
    assign r_try = {rr_reg[SW-1:0], rn_reg[NW-1]} - {1'b0, h_reg};

    assign stat.empty    = (w_reg == '0) || (h_reg == '0);
    assign stat.div_done = !dbusy_reg;
    assign stat.row_end  = (x_reg == w_reg - SW'(1));
    assign stat.pix_last = stat.row_end && (y_reg == h_reg - SW'(1));
    assign stat.drain    = !p_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg   <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
                dbusy_reg <= 1'b1;
            else if (dbusy_reg && dcnt_reg == DCW'(NW - 1))
                dbusy_reg <= 1'b0;
            p_valid_reg <= cmd.pix_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
            x_reg <= '0;
            y_reg <= '0;
            rowdiv_reg <= 1'b1;
            if (item.kind == KIND_LOAD)
                image_mem[IW'(item.address)] <= item.pixel_value;
        end
        if (cmd.size_start)
        begin
            // floor(ratio*SCREEN/255) by reciprocal multiply
            w_reg <= SW'((64'(item_reg.width_ratio) * 64'(W_MUL)) >> 26);
            h_reg <= SW'((64'(item_reg.height_ratio) * 64'(H_MUL)) >> 26);
        end
        if (cmd.div_start)
        begin
            cn_reg <= NW'(32'(x_reg) * 32'(res));
            rn_reg <= NW'(32'(y_reg) * 32'(res));
            cr_reg <= '0;
            rr_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            cn_reg <= {cn_reg[NW-2:0], !c_try[SW]};
            rn_reg <= {rn_reg[NW-2:0], !r_try[SW]};
            cr_reg <= c_try[SW] ? {cr_reg[SW-1:0], cn_reg[NW-1]} : c_try;
            rr_reg <= r_try[SW] ? {rr_reg[SW-1:0], rn_reg[NW-1]} : r_try;
            dcnt_reg <= dcnt_reg + DCW'(1);
            if (dcnt_reg == DCW'(NW - 1))
            begin
                cq_reg <= QW'({cn_reg[NW-2:0], !c_try[SW]});
                if (rowdiv_reg)
                    rq_reg <= QW'({rn_reg[NW-2:0], !r_try[SW]});
                rowdiv_reg <= 1'b0;
            end
        end
        if (cmd.pix_issue)
        begin
            img_q_reg   <= image_mem[iaddr];
            p_on_reg    <= on_scr;
            p_faddr_reg <= FW'(faddr_wide);
            if (stat.row_end)
            begin
                x_reg <= '0;
                y_reg <= y_reg + SW'(1);
                rowdiv_reg <= 1'b1;
            end
            else
                x_reg <= x_reg + SW'(1);
        end
        if (p_valid_reg && p_on_reg)
        begin
            if (img_q_reg != '0)
                frame_mem[p_faddr_reg] <= img_q_reg;
            else if (item_reg.is_background)
                frame_mem[p_faddr_reg] <= OPAQUE_WHITE;
        end
        if (cmd.read_issue)
        begin
            frd_q_reg <= frame_mem[FW'(item_reg.address)];
            rd_ok_reg <= 32'(item_reg.address) < FRAME_WORDS;
        end
    end

    assign result.done_kind  = item_reg.kind;
    assign result.read_color = (item_reg.kind == KIND_READ && rd_ok_reg) ? frd_q_reg : '0;

endmodule

[test/ssb_checker.sv]
// Checker for the scaled sprite blitter: watches the command and result ports,
// keeps its own image and frame stores, predicts each result and compares.
// Depends on ssb_pkg.
module ssb_checker
    import ssb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  item_t                    item,
    input  logic                     done,
    input  result_t                  result,
    output int                       errors,
    output int                       outstanding,
    output logic [SCREEN_W_DEF*SCREEN_H_DEF-1:0] frame_known
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_WORDS = SCREEN_W_DEF * SCREEN_H_DEF;

    logic [15:0] image_mem [IMAGE_WORDS_DEF];
    logic [15:0] frame_mem [FRAME_WORDS];
    result_t     pending_done [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        frame_known = '0;
    end

    // Nearest-neighbor blit into the local frame copy.
    task automatic blit_frame(input item_t it);
        int res, w, h, py, px, row, col, idx;
        logic [15:0] color;
        res = it.is_background ? BG_RES_DEF : SPRITE_RES_DEF;
        w   = int'(it.width_ratio) * SCREEN_W_DEF / 255;
        h   = int'(it.height_ratio) * SCREEN_H_DEF / 255;
        if (w == 0 || h == 0)
            return;
        for (int y = 0; y < h; y++)
        begin
            py = int'(it.screen_y) + y;
            if (py < 0 || py >= SCREEN_H_DEF)
                continue;
            row = y * res / h;
            for (int x = 0; x < w; x++)
            begin
                px = int'(it.screen_x) + x;
                if (px < 0 || px >= SCREEN_W_DEF)
                    continue;
                col   = x * res / w;
                idx   = (int'(it.image_base) + row * res + col) % IMAGE_WORDS_DEF;
                color = image_mem[idx];
                if (color == 16'h0000)
                begin
                    if (!it.is_background)
                        continue;
                    color = OPAQUE_WHITE;
                end
                frame_mem[py * SCREEN_W_DEF + px] = color;
                frame_known[py * SCREEN_W_DEF + px] = 1'b1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_done.size() == 0)
            begin
                $error("unexpected result transaction: read_color %h done_kind %0d",
                       result.read_color, result.done_kind);
                errors = errors + 1;
            end
            else
            begin
                want = pending_done.pop_front();
                if (result.read_color !== want.read_color)
                begin
                    $error("read_color: expected %h, actual %h",
                           want.read_color, result.read_color);
                    errors = errors + 1;
                end
                if (result.done_kind !== want.done_kind)
                begin
                    $error("done_kind: expected %0d, actual %0d",
                           want.done_kind, result.done_kind);
                    errors = errors + 1;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            want.read_color = 16'h0000;
            want.done_kind  = item.kind;
            case (kind_t'(item.kind))
                KIND_LOAD: image_mem[int'(item.address) % IMAGE_WORDS_DEF] = item.pixel_value;
                KIND_DRAW: blit_frame(item);
                KIND_READ:
                    if (int'(item.address) < FRAME_WORDS)
                        want.read_color = frame_mem[item.address];
                default: ;
            endcase
            pending_done.push_back(want);
        end
        outstanding <= pending_done.size();
    end

endmodule

[test/scaled_sprite_blitter_unit_tb.sv]
// Testbench top for scaled_sprite_blitter_unit: drives load, draw, read and
// unused-kind transactions and gives the verdict. Depends on ssb_pkg, ssb_checker.
module scaled_sprite_blitter_unit_tb;
    import ssb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_WORDS = SCREEN_W_DEF * SCREEN_H_DEF;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;
    int      errors;
    int      outstanding;
    logic [FRAME_WORDS-1:0] frame_known;

    bit      image_loaded [IMAGE_WORDS_DEF];
    int      gap_pct = 0;

    always #4 clk = ~clk;

    scaled_sprite_blitter_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    ssb_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding),
        .frame_known (frame_known)
    );

    function automatic logic [15:0] rand_color();
        return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    endfunction

    function automatic item_t noise_item(input kind_t k);
        item_t it;
        it = item_t'(($bits(item_t))'({$urandom, $urandom, $urandom, $urandom}));
        it.kind = k;
        return it;
    endfunction

    task automatic send(input item_t it);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (it.kind == KIND_LOAD)
            image_loaded[it.address] = 1'b1;
        // After a draw, drop start so the checker's frame view settles before a read.
        if (it.kind == KIND_DRAW)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Load every not yet loaded image word that the draw's on-screen pixels sample, then issue the draw.
    task automatic draw(input item_t it);
        int res, w, h, py, px, idx;
        item_t ld;
        it.kind = KIND_DRAW;
        res = it.is_background ? BG_RES_DEF : SPRITE_RES_DEF;
        w   = int'(it.width_ratio) * SCREEN_W_DEF / 255;
        h   = int'(it.height_ratio) * SCREEN_H_DEF / 255;
        if (w > 0 && h > 0)
        begin
            for (int y = 0; y < h; y++)
            begin
                py = int'(it.screen_y) + y;
                if (py < 0 || py >= SCREEN_H_DEF)
                    continue;
                for (int x = 0; x < w; x++)
                begin
                    px = int'(it.screen_x) + x;
                    if (px < 0 || px >= SCREEN_W_DEF)
                        continue;
                    idx = (int'(it.image_base) + (y * res / h) * res + x * res / w)
                          % IMAGE_WORDS_DEF;
                    if (!image_loaded[idx])
                    begin
                        ld = noise_item(KIND_LOAD);
                        ld.address     = 16'(idx);
                        ld.pixel_value = rand_color();
                        send(ld);
                    end
                end
            end
        end
        send(it);
    endtask

    task automatic draw_at(input logic [15:0] base, input int sx, input int sy,
                           input int wr, input int hr, input logic bg);
        item_t it;
        it = noise_item(KIND_DRAW);
        it.image_base    = base;
        it.screen_x      = 16'(sx);
        it.screen_y      = 16'(sy);
        it.width_ratio   = 8'(wr);
        it.height_ratio  = 8'(hr);
        it.is_background = bg;
        draw(it);
    endtask

    // Read a frame pixel already written, or an address past the end of the frame.
    task automatic read_frame(input bit in_range);
        item_t it;
        int    a;
        bit    found;
        it = noise_item(KIND_READ);
        found = 1'b0;
        if (in_range)
        begin
            a = $urandom_range(0, FRAME_WORDS - 1);
            for (int i = 0; i < FRAME_WORDS && !found; i++)
                if (frame_known[(a + i) % FRAME_WORDS])
                begin
                    it.address = 16'((a + i) % FRAME_WORDS);
                    found = 1'b1;
                end
        end
        if (!found)
            it.address = 16'($urandom_range(FRAME_WORDS, 65535));
        send(it);
    endtask

    task automatic load_word(input logic [15:0] a, input logic [15:0] v);
        item_t it;
        it = noise_item(KIND_LOAD);
        it.address     = a;
        it.pixel_value = v;
        send(it);
    endtask

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        item_t it;
        int    pick, sx, sy, wr, hr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        gap_pct = 15;
        load_word(16'h0000, 16'hFFFF);
        load_word(16'hFFFF, 16'h0000);
        send(noise_item(KIND_NONE));
        read_frame(1'b0);
        it = noise_item(KIND_READ);
        it.address = 16'(FRAME_WORDS);
        send(it);
        draw_at(16'h1234, 0, 0, 0, 200, 1'b1);       // zero width
        draw_at(16'h1234, 0, 0, 255, 1, 1'b0);       // width 128 but height 0
        draw_at(16'h0000, 0, 0, 30, 30, 1'b1);        // background at origin
        draw_at(16'h4000, -5, -3, 40, 40, 1'b0);      // sprite clipped top-left
        draw_at(16'h2000, 120, 120, 30, 30, 1'b1);    // clipped bottom-right
        draw_at(16'h3000, 32767, -32768, 255, 255, 1'b0); // fully off screen
        draw_at(16'hFFF0, 10, 10, 60, 60, 1'b0);      // image address wraps
        draw_at(16'h8000, 0, 127, 255, 2, 1'b1);      // full-width background row
        draw_at(16'h6000, 0, 0, 255, 255, 1'b0);      // full-screen sprite
        it = noise_item(KIND_READ);
        it.address = 16'(FRAME_WORDS - 1);
        if (frame_known[FRAME_WORDS - 1])
            send(it);
        read_frame(1'b1);
        read_frame(1'b1);
        load_word(16'h5555, 16'hAAAA);

        // Random part in three idling phases.
        for (int n = 0; n < 100; n++)
        begin
            gap_pct = (n < 33) ? 15 : (n < 66) ? 87 : 0;
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    sx = $urandom_range(0, 150) - 20;
                    sy = $urandom_range(0, 150) - 20;
                end
                else
                begin
                    sx = $signed(16'($urandom));
                    sy = $signed(16'($urandom));
                end
                // Keep most draws small; a few stretch one axis wide.
                wr = $urandom_range(0, 24);
                hr = $urandom_range(0, 24);
                if ($urandom_range(0, 9) < 2)
                begin
                    wr = $urandom_range(128, 255);
                    hr = $urandom_range(0, 6);
                end
                else if ($urandom_range(0, 9) < 1)
                begin
                    hr = $urandom_range(128, 255);
                    wr = $urandom_range(0, 6);
                end
                draw_at(16'($urandom), sx, sy, wr, hr, 1'($urandom));
            end
            else if (pick < 70)
                read_frame($urandom_range(0, 4) != 0);
            else if (pick < 90)
                load_word(16'($urandom), rand_color());
            else
                send(noise_item(KIND_NONE));
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/ssb_pkg.sv
sv/ssb_ctrl.sv
sv/ssb_datapath.sv
sv/scaled_sprite_blitter_unit.sv
test/ssb_checker.sv
test/scaled_sprite_blitter_unit_tb.sv
